### sv/locd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locd_pkg: shared types and constants of the LRU object cache directory
// Request and result structs, command and status structs between the
// controller and the datapath, age constants and request codes.
// ----------------------------------------------------------------------------
package locd_pkg;

  // Default sizing of the directory.
  localparam int ENTRIES_DEF     = 16;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;

  // Fixed widths of the request and result fields.
  localparam int KEY_W        = 64;
  localparam int HANDLE_W     = 32;
  localparam int SLOT_W       = 4;
  localparam int OUT_HANDLE_W = 32;

  // Age counter: a touched entry gets the top age, other valid entries step down
  localparam int              AGE_W    = 14;
  localparam logic [AGE_W-1:0] AGE_TOP  = 14'd9999;
  localparam logic [AGE_W-1:0] AGE_STEP = 14'd1;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } locd_in_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_W-1:0]       slot;
    logic [OUT_HANDLE_W-1:0] handle_out;
    logic                    replaced;
  } locd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch request, reset the scan
    logic scan_rd;  // read entry at the pointer for the match/victim scan
    logic age_rd;   // read entry at the pointer for the age update pass
    logic decide;   // capture target entry and result fields
    logic commit;   // request touches an entry: write it on insert
    logic emit;     // present the result next cycle
  } locd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_last;  // pointer is at the last entry
    logic miss;      // lookup found no valid matching entry
  } locd_sts_t;

endpackage

### sv/locd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locd_ctrl: sequencer of the LRU object cache directory
// Steps each request through a scan pass over all entries, a decision
// cycle and, unless a lookup misses, an age update pass.
// ----------------------------------------------------------------------------
module locd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  locd_pkg::locd_sts_t sts,
  output locd_pkg::locd_cmd_t cmd
);
  import locd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN     = 6'b000010,
    S_SCAN_END = 6'b000100,
    S_DECIDE   = 6'b001000,
    S_AGE      = 6'b010000,
    S_AGE_END  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // The last entry read is evaluated in this cycle.
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.miss) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_AGE;
        end
      end
      S_AGE: begin
        cmd.age_rd = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_AGE_END;
        end
      end
      S_AGE_END: begin
        // The last age write-back happens in this cycle.
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The controller never issues two phase commands at once.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_rd, cmd.age_rd, cmd.commit}))
    else $error("conflicting datapath commands");

  // After the result is issued the block is free again.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !busy)
    else $error("block still busy after result");
`endif

endmodule

### sv/locd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locd_dp: datapath of the LRU object cache directory
// Key, handle and age memories, valid bits, one shared key comparator and
// age comparator for the scan, and the age read-modify-write pipeline.
// ----------------------------------------------------------------------------
module locd_dp #(
  parameter int ENTRIES     = locd_pkg::ENTRIES_DEF,
  parameter int KEY_BITS    = locd_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = locd_pkg::HANDLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  locd_pkg::locd_in_t  in_req,
  input  locd_pkg::locd_cmd_t cmd,
  output locd_pkg::locd_sts_t sts,
  output logic                out_valid,
  output locd_pkg::locd_out_t out_res
);
  import locd_pkg::*;

  localparam int               IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Entry storage.
  logic [KEY_BITS-1:0]    key_mem    [ENTRIES];
  logic [HANDLE_BITS-1:0] handle_mem [ENTRIES];
  logic [AGE_W-1:0]       age_mem    [ENTRIES];
  logic [ENTRIES-1:0]     valid_r;

  // Latched request.
  logic                   req_type_r;
  logic [KEY_BITS-1:0]    req_key_r;
  logic [HANDLE_BITS-1:0] req_handle_r;

  // Read pointer and read pipeline stage.
  logic [IDX_W-1:0]       ptr_r;
  logic                   rd_vld_r;
  logic                   rd_age_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [KEY_BITS-1:0]    key_q_r;
  logic [HANDLE_BITS-1:0] handle_q_r;
  logic [AGE_W-1:0]       age_q_r;

  // Scan results.
  logic                   match_r;
  logic [IDX_W-1:0]       match_idx_r;
  logic [HANDLE_BITS-1:0] match_handle_r;
  logic                   empty_r;
  logic [IDX_W-1:0]       empty_idx_r;
  logic                   seen_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [AGE_W-1:0]       best_age_r;
  logic [IDX_W-1:0]       target_r;

  logic                   out_valid_r;
  locd_out_t              out_res_r;

  logic                   is_ins_c;
  logic                   miss_c;
  logic                   entry_vld_c;
  logic                   scan_ev_c;
  logic                   key_eq_c;
  logic [IDX_W-1:0]       tgt_c;
  logic [AGE_W-1:0]       age_dec_c;
  logic [AGE_W-1:0]       age_new_c;
  locd_out_t              res_c;

  // Decode of the latched request and the entry under evaluation.
  assign is_ins_c    = (req_type_r == REQ_INSERT);
  assign miss_c      = !is_ins_c && !match_r;
  assign entry_vld_c = valid_r[rd_idx_r];
  assign scan_ev_c   = rd_vld_r && !rd_age_r;
  assign key_eq_c    = (key_q_r == req_key_r);

  // Target entry: the hit for a lookup; the first empty or the oldest entry
  // for an insert.
  assign tgt_c = !is_ins_c ? match_idx_r : (empty_r ? empty_idx_r : best_idx_r);

  // Result fields.
  always_comb begin
    res_c.hit        = !is_ins_c && match_r;
    res_c.slot       = miss_c ? '0 : SLOT_W'(tgt_c);
    res_c.handle_out = res_c.hit ? OUT_HANDLE_W'(match_handle_r) : '0;
    res_c.replaced   = is_ins_c && !empty_r;
  end

  // New age: top for the touched entry, a saturating step down for the
  // other valid entries, unchanged for empty ones.
  assign age_dec_c = (age_q_r >= AGE_STEP) ? (age_q_r - AGE_STEP) : '0;
  assign age_new_c = (rd_idx_r == target_r) ? AGE_TOP :
                     (entry_vld_c ? age_dec_c : age_q_r);

  // Pointer and read pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_age_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr_r <= '0;
      end else if (cmd.scan_rd || cmd.age_rd) begin
        ptr_r <= (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
      end
      rd_vld_r <= cmd.scan_rd || cmd.age_rd;
      rd_age_r <= cmd.age_rd;
    end
  end

  // Memory reads at the pointer.
  always_ff @(posedge clk) begin
    rd_idx_r <= ptr_r;
    if (cmd.scan_rd || cmd.age_rd) begin
      key_q_r    <= key_mem[ptr_r];
      handle_q_r <= handle_mem[ptr_r];
      age_q_r    <= age_mem[ptr_r];
    end
  end

  // Memory writes: key and handle on insert, ages during the update pass.
  always_ff @(posedge clk) begin
    if (cmd.commit && is_ins_c) begin
      key_mem[tgt_c]    <= req_key_r;
      handle_mem[tgt_c] <= req_handle_r;
    end
    if (rd_vld_r && rd_age_r) begin
      age_mem[rd_idx_r] <= age_new_c;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && is_ins_c) begin
      valid_r[tgt_c] <= 1'b1;
    end
  end

  // Request latch and scan evaluation: first match, first empty entry and
  // lowest-indexed valid entry with the smallest age.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r   <= in_req.req_type;
      req_key_r    <= KEY_BITS'(in_req.key);
      req_handle_r <= HANDLE_BITS'(in_req.handle);
      match_r      <= 1'b0;
      empty_r      <= 1'b0;
      seen_r       <= 1'b0;
    end else if (scan_ev_c) begin
      if (entry_vld_c && key_eq_c && !match_r) begin
        match_r        <= 1'b1;
        match_idx_r    <= rd_idx_r;
        match_handle_r <= handle_q_r;
      end
      if (!entry_vld_c && !empty_r) begin
        empty_r     <= 1'b1;
        empty_idx_r <= rd_idx_r;
      end
      if (entry_vld_c && (!seen_r || (age_q_r < best_age_r))) begin
        seen_r     <= 1'b1;
        best_idx_r <= rd_idx_r;
        best_age_r <= age_q_r;
      end
    end
  end

  // Target and result capture.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      target_r  <= tgt_c;
      out_res_r <= res_c;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign sts.ptr_last = (ptr_r == LAST_IDX);
  assign sts.miss     = miss_c;
  assign out_valid    = out_valid_r;
  assign out_res      = out_res_r;

`ifndef SYNTHESIS
  // A result strobe lasts a single cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  // A hit comes only from a lookup, which never replaces an entry.
  a_hit_no_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.hit) |-> !out_res_r.replaced)
    else $error("result reports both hit and replacement");

  // An inserted entry is valid once written.
  a_ins_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_ins_c) |=> valid_r[target_r])
    else $error("inserted entry not marked valid");
`endif

endmodule

### sv/lru_object_cache_directory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_object_cache_directory: fully associative LRU object directory
// Looks up keys among ENTRIES entries and inserts key/handle pairs with
// least-recently-used replacement, aging all valid entries on each touch.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   -------   ------------------  --------------------------------------
//   request   start / busy        in_req  (req_type, key, handle)
//   result    out_valid strobe    out_res (hit, slot, handle_out, replaced)
//
// A request is taken at a clock edge with start high and busy low.
// A lookup miss runs one scan pass over the memories before its result strobe;
// a hit or an insert runs one scan pass and one age update pass over the
// memories, one entry per cycle each.
// A new request is taken in the cycle the result strobe is high.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// After reset all entries are empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_object_cache_directory #(
  parameter int ENTRIES     = locd_pkg::ENTRIES_DEF,
  parameter int KEY_BITS    = locd_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = locd_pkg::HANDLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  locd_pkg::locd_in_t  in_req,
  output logic                out_valid,
  output locd_pkg::locd_out_t out_res
);
  import locd_pkg::*;

  locd_cmd_t cmd;
  locd_sts_t sts;

  // Request sequencer.
  locd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Entry storage and scan logic.
  locd_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU object cache directory
// Sends lookup and insert requests over the start/busy handshake and predicts
// each result with a bit-accurate directory model kept in this file. Results
// are checked field by field, in order. Directed tests cover the empty and
// full directory, duplicate keys, replacement and a long run of hits on one
// entry. Random phases with and without sender gaps follow.
// ----------------------------------------------------------------------------
module testbench;
  import locd_pkg::*;

  localparam int ENTRIES   = ENTRIES_DEF;
  localparam int POOL_SIZE = 24;
  localparam int HOT_RUN   = 32;
  localparam int SETTLE    = 2 * ENTRIES + 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  locd_in_t  in_req = '0;
  logic      out_valid;
  locd_out_t out_res;

  lru_object_cache_directory u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  always #4 clk = ~clk;

  // Mirror of the directory contents.
  logic              dir_valid  [ENTRIES];
  logic [AGE_W-1:0]  dir_age    [ENTRIES];
  logic [KEY_W-1:0]  dir_key    [ENTRIES];
  logic [HANDLE_W-1:0] dir_handle [ENTRIES];

  locd_out_t         pending_results[$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  logic [KEY_W-1:0]  recent_key = '0;
  locd_out_t         want;

  int n_fail = 0;
  int n_sent = 0;
  int n_hit = 0;
  int n_miss = 0;
  int n_insert = 0;
  int n_replaced = 0;

  // The touched entry gets the top age; every other valid entry ages by one,
  // stopping at zero.
  function automatic void age_entries(input int idx);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i == idx) begin
        dir_age[i] = AGE_TOP;
      end else if (dir_valid[i] && dir_age[i] >= AGE_STEP) begin
        dir_age[i] = dir_age[i] - AGE_STEP;
      end else if (dir_valid[i]) begin
        dir_age[i] = '0;
      end
    end
  endfunction

  // Computes the result of one request and updates the mirrored directory.
  function automatic locd_out_t resolve_request(input locd_in_t req);
    locd_out_t res;
    int        victim;
    logic [AGE_W-1:0] best_age;
    res = '0;
    if (req.req_type == REQ_LOOKUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (dir_valid[i] && dir_key[i] == req.key) begin
          res.hit        = 1'b1;
          res.slot       = SLOT_W'(i);
          res.handle_out = dir_handle[i];
          age_entries(i);
          break;
        end
      end
    end else begin
      // First empty entry wins; otherwise the lowest index with the smallest age.
      victim = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!dir_valid[i]) begin
          victim = i;
          break;
        end
      end
      if (victim < 0) begin
        victim   = 0;
        best_age = dir_age[0];
        for (int i = 1; i < ENTRIES; i++) begin
          if (dir_age[i] < best_age) begin
            victim   = i;
            best_age = dir_age[i];
          end
        end
      end
      res.slot           = SLOT_W'(victim);
      res.replaced       = dir_valid[victim];
      dir_key[victim]    = req.key;
      dir_handle[victim] = req.handle;
      dir_valid[victim]  = 1'b1;
      age_entries(victim);
    end
    return res;
  endfunction

  function automatic locd_in_t make_req(input logic kind, input logic [KEY_W-1:0] key,
                                        input logic [HANDLE_W-1:0] handle);
    locd_in_t req;
    req.req_type = kind;
    req.key      = key;
    req.handle   = handle;
    return req;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // Presents one request from a falling edge and holds it until it is taken.
  task automatic send_req(input locd_in_t req);
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(resolve_request(req));
    if (req.req_type == REQ_INSERT) begin
      recent_key = req.key;
      n_insert++;
    end
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the request side quiet until every predicted result has arrived.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result checker: each strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding: %p", out_res);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (out_res.hit !== want.hit) begin
          $error("hit mismatch: expected %0d, got %0d", want.hit, out_res.hit);
          n_fail++;
        end
        if (out_res.slot !== want.slot) begin
          $error("slot mismatch: expected %0d, got %0d", want.slot, out_res.slot);
          n_fail++;
        end
        if (out_res.handle_out !== want.handle_out) begin
          $error("handle_out mismatch: expected %h, got %h", want.handle_out,
                 out_res.handle_out);
          n_fail++;
        end
        if (out_res.replaced !== want.replaced) begin
          $error("replaced mismatch: expected %0d, got %0d", want.replaced,
                 out_res.replaced);
          n_fail++;
        end
        if (want.hit) n_hit++;
        else if (want.replaced) n_replaced++;
      end
    end
  end

  // Lookups on an empty directory must miss.
  task automatic test_empty_lookup();
    send_req(make_req(REQ_LOOKUP, '0, '0));
    send_req(make_req(REQ_LOOKUP, '1, '1));
    drain();
  endtask

  // Fill every entry, using the key and handle extremes in the first slots.
  task automatic test_fill();
    send_req(make_req(REQ_INSERT, '0, '0));
    send_req(make_req(REQ_INSERT, '1, '1));
    send_req(make_req(REQ_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555));
    send_req(make_req(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA));
    for (int i = 4; i < ENTRIES; i++) begin
      send_req(make_req(REQ_INSERT, {$urandom, $urandom}, $urandom));
    end
    drain();
  endtask

  // Hits on the newest and oldest entries and a miss that leaves ages alone.
  task automatic test_hits();
    send_req(make_req(REQ_LOOKUP, recent_key, $urandom));
    send_req(make_req(REQ_LOOKUP, '0, '1));
    send_req(make_req(REQ_LOOKUP, 64'h0123_4567_89AB_CDEF, '0));
    send_req(make_req(REQ_LOOKUP, '1, '0));
    drain();
  endtask

  // A second copy of a key lands elsewhere; a lookup finds the lower index.
  task automatic test_duplicate_key();
    send_req(make_req(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hDEAD_BEEF));
    send_req(make_req(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0));
    drain();
  endtask

  // Inserts into a full directory evict the least recently used entries.
  task automatic test_replacement();
    for (int i = 0; i < 3; i++) begin
      send_req(make_req(REQ_INSERT, {$urandom, $urandom}, $urandom));
    end
    drain();
  endtask

  // Repeated hits on one entry age all the others, so the following inserts
  // must pass over the hot entry and evict the ones touched longest ago.
  task automatic test_hot_entry();
    for (int i = 0; i < HOT_RUN; i++) begin
      send_req(make_req(REQ_LOOKUP, recent_key, $urandom));
    end
    send_req(make_req(REQ_INSERT, {$urandom, $urandom}, $urandom));
    send_req(make_req(REQ_INSERT, {$urandom, $urandom}, $urandom));
    drain();
  endtask

  // Random mix of lookups and inserts over a small key pool, with gaps when idle_pct is nonzero.
  task automatic test_random(input int count, input int idle_pct);
    logic kind;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      kind = 1'($urandom_range(1));
      send_req(make_req(kind, pick_key(), $urandom));
      if ($urandom_range(99) < idle_pct) idle_for($urandom_range(1, SETTLE));
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i]  = 1'b0;
      dir_age[i]    = '0;
      dir_key[i]    = '0;
      dir_handle[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_lookup();
    test_fill();
    test_hits();
    test_duplicate_key();
    test_replacement();
    test_hot_entry();
    test_random(400, 0);
    test_random(400, 68);
    test_random(400, 38);

    repeat (SETTLE) @(posedge clk);
    n_miss = n_sent - n_hit - n_insert;
    $display("Ran %0d requests: %0d lookup hits, %0d lookup misses, %0d inserts.",
             n_sent, n_hit, n_miss, n_insert);
    $display("Inserts replacing a live entry: %0d.", n_replaced);
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(64'd50_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
